FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation block
// Operand width, controller state encoding and the modular add helper.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // width of the arithmetic datapath (2 .. 64)
  localparam int OperandWidth = 64;
  // width of the payload ports
  localparam int FieldWidth   = 64;

  typedef logic [OperandWidth-1:0] operand_t;

  // controller states, one-hot
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StReduce = 6'b000010,
    StCheck  = 6'b000100,
    StMulP   = 6'b001000,
    StSquare = 6'b010000,
    StResult = 6'b100000
  } mexp_state_e;

  // (a + b) mod m for a, b < m
  function automatic operand_t add_mod(operand_t a, operand_t b, operand_t m);
    logic [OperandWidth:0] sum;
    logic [OperandWidth:0] diff;
    sum  = {1'b0, a} + {1'b0, b};
    diff = sum - {1'b0, m};
    return (sum >= {1'b0, m}) ? diff[OperandWidth-1:0] : sum[OperandWidth-1:0];
  endfunction

endpackage

FILE: rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod: bit-serial modular multiplier
// Double-and-add over the multiplier bits, one bit per cycle, lsb first.
// Stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mexp_pkg::operand_t x_i,
  input  mexp_pkg::operand_t y_i,
  input  mexp_pkg::operand_t m_i,
  output logic               done_o,
  output mexp_pkg::operand_t result_o
);

  mexp_pkg::operand_t acc_q, acc_d;
  mexp_pkg::operand_t x_q, x_d;
  mexp_pkg::operand_t y_q, y_d;
  mexp_pkg::operand_t m_q;
  logic               running_q, running_d;
  logic               done_q, done_d;

  // one double-and-add step
  always_comb begin
    acc_d     = acc_q;
    x_d       = x_q;
    y_d       = y_q;
    running_d = running_q;
    done_d    = 1'b0;
    if (start_i) begin
      acc_d     = '0;
      x_d       = x_i;
      y_d       = y_i;
      running_d = 1'b1;
    end else if (running_q) begin
      if (y_q == '0) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end else begin
        if (y_q[0]) begin
          acc_d = mexp_pkg::add_mod(acc_q, x_q, m_q);
        end
        x_d = mexp_pkg::add_mod(x_q, x_q, m_q);
        y_d = y_q >> 1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    if (start_i) begin
      m_q <= m_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus
// Right-to-left square and multiply over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is shown. The result appears for one cycle with
// result_valid_o and must be captured then, as the block cannot be stalled.
// All work runs through one shared bit-serial multiplier that retires one
// multiplier bit per cycle and stops once the remaining bits are zero; each
// multiplication holds the sequencer until the multiplier is done. An item
// costs one reduction of the base, then for every exponent bit up to its
// highest set bit a check, a multiplication where the bit is set and a
// squaring, then a final check and the result cycle. Short exponents or
// operands finish sooner. A zero modulus answers in the cycle after the
// transfer with the error flag set and result 0.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mexp_pkg::FieldWidth-1:0]   base_value_i,
  input  logic [mexp_pkg::FieldWidth-1:0]   exponent_value_i,
  input  logic [mexp_pkg::FieldWidth-1:0]   modulus_value_i,
  output logic                              result_valid_o,
  output logic [mexp_pkg::FieldWidth-1:0]   power_result_o,
  output logic                              zero_modulus_error_o
);

  mexp_pkg::mexp_state_e state_q, state_d;
  logic                  mul_start_q, mul_start_d;
  logic                  mul_done;
  mexp_pkg::operand_t    mul_x, mul_y, mul_res, one_mod;

  mexp_pkg::operand_t    base_q, exp_q, mod_q, prod_q, sq_q;
  mexp_pkg::operand_t    in_base, in_exp, in_mod;
  logic                  err_q;

  logic                  accept;

  assign accept  = start && !busy;
  assign in_base = base_value_i[mexp_pkg::OperandWidth-1:0];
  assign in_exp  = exponent_value_i[mexp_pkg::OperandWidth-1:0];
  assign in_mod  = modulus_value_i[mexp_pkg::OperandWidth-1:0];

  // 1 reduced modulo the modulus
  assign one_mod = (mod_q == mexp_pkg::operand_t'(1)) ? '0 : mexp_pkg::operand_t'(1);

  // multiplier operand selection
  always_comb begin
    unique case (state_q)
      mexp_pkg::StReduce: begin
        mul_x = one_mod;
        mul_y = base_q;
      end
      mexp_pkg::StMulP: begin
        mul_x = prod_q;
        mul_y = sq_q;
      end
      default: begin
        mul_x = sq_q;
        mul_y = sq_q;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .x_i      (mul_x),
    .y_i      (mul_y),
    .m_i      (mod_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    mul_start_d = 1'b0;
    unique case (state_q)
      mexp_pkg::StIdle: begin
        if (start) begin
          if (in_mod == '0) begin
            state_d = mexp_pkg::StResult;
          end else begin
            state_d     = mexp_pkg::StReduce;
            mul_start_d = 1'b1;
          end
        end
      end
      mexp_pkg::StReduce: begin
        if (mul_done) begin
          state_d = mexp_pkg::StCheck;
        end
      end
      mexp_pkg::StCheck: begin
        if (exp_q == '0) begin
          state_d = mexp_pkg::StResult;
        end else if (exp_q[0]) begin
          state_d     = mexp_pkg::StMulP;
          mul_start_d = 1'b1;
        end else begin
          state_d     = mexp_pkg::StSquare;
          mul_start_d = 1'b1;
        end
      end
      mexp_pkg::StMulP: begin
        if (mul_done) begin
          state_d     = mexp_pkg::StSquare;
          mul_start_d = 1'b1;
        end
      end
      mexp_pkg::StSquare: begin
        if (mul_done) begin
          state_d = mexp_pkg::StCheck;
        end
      end
      mexp_pkg::StResult: begin
        state_d = mexp_pkg::StIdle;
      end
      default: begin
        state_d = mexp_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::StIdle;
      mul_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_start_q <= mul_start_d;
    end
  end

  // operand and running values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q <= in_base;
      exp_q  <= in_exp;
      mod_q  <= in_mod;
      err_q  <= (in_mod == '0);
      // product starts at 1, already reduced unless the exponent is zero; 0 for a zero modulus
      if (in_mod == '0) begin
        prod_q <= '0;
      end else if (in_exp != '0 && in_mod == mexp_pkg::operand_t'(1)) begin
        prod_q <= '0;
      end else begin
        prod_q <= mexp_pkg::operand_t'(1);
      end
    end else if (mul_done) begin
      if (state_q == mexp_pkg::StMulP) begin
        prod_q <= mul_res;
      end else if (state_q == mexp_pkg::StSquare) begin
        sq_q  <= mul_res;
        exp_q <= exp_q >> 1;
      end else begin
        sq_q <= mul_res;
      end
    end
  end

  // result transfer
  assign busy                 = (state_q != mexp_pkg::StIdle);
  assign result_valid_o       = (state_q == mexp_pkg::StResult);
  assign power_result_o       = mexp_pkg::FieldWidth'(prod_q);
  assign zero_modulus_error_o = err_q;

  // assertions
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy)
    else $error("block not idle after result transfer");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && zero_modulus_error_o) |-> (power_result_o == '0))
    else $error("zero modulus result not zero");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mexp_pkg::StReduce || state_q == mexp_pkg::StMulP ||
                  state_q == mexp_pkg::StSquare))
    else $error("multiplier finished outside a multiply state");

  a_check_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::StCheck && exp_q == '0) |=> result_valid_o)
    else $error("exhausted exponent did not lead to result");

endmodule
